>>> src/gfre_pkg.sv
package gfre_pkg;

	// sample and kernel geometry
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_RADIUS  = 6;
	localparam int WIN         = 2 * MAX_RADIUS + 1;
	localparam int WIN_IDX_W   = $clog2(WIN);
	localparam int POS_SAT     = 2 * MAX_RADIUS + 2;
	localparam int POS_W       = $clog2(POS_SAT + 1);
	localparam int TAP_COUNT   = 7;
	localparam int TAP_IDX_W   = $clog2(TAP_COUNT);
	localparam int TAP_W       = 16;
	localparam int RAD_W       = 3;
	localparam int J_W         = $clog2(WIN);

	// arithmetic widths
	localparam int FRAC_BITS = 15;
	localparam int PROD_W    = SAMPLE_BITS + TAP_W + 1;
	localparam int ACC_W     = PROD_W + 4;

	// configuration port
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_TAP_CENTER = REG_IDX_W'(1);
	localparam logic [TAP_W-1:0]     TAP_ONE        = TAP_W'(32768);

	// small queues between the parts
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [TAP_COUNT-1:0][TAP_W-1:0] tap_arr_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_ONE,
		CMD_SHORT,
		CMD_FLUSH
	} cmd_kind_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		cmd_kind_t                     kind;
		logic [POS_W-1:0]              m;
		logic [RAD_W-1:0]              r;
	} cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered;
		logic                          final_result;
		logic                          too_short;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAC,
		BK_DRAIN,
		BK_OUT,
		BK_SHORT
	} bk_state_t;

endpackage

>>> src/gfre_front.sv
module gfre_front
	import gfre_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          end_of_block,
	input  logic [RAD_W-1:0]              radius,
	output logic                          cmd_valid,
	output cmd_t                          cmd,
	input  logic                          cmd_pop
);

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_next;
	logic [POS_W-1:0]  m_c;
	logic [RAD_W-1:0]  r_c;
	cmd_kind_t         kind_c;
	logic              accept;
	cmd_t              cmd_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign accept    = push && !full;
	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cmd_mem_q[rd_ptr_q];

	// classify the incoming sample by block position
	always_comb begin
		r_c      = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
		pos_next = (pos_q < POS_W'(POS_SAT)) ? pos_q + POS_W'(1) : pos_q;
		m_c      = pos_next - POS_W'(1);
		if (!end_of_block) begin
			kind_c = (m_c >= POS_W'(r_c)) ? CMD_ONE : CMD_NONE;
		end else begin
			kind_c = (pos_next < POS_W'(r_c)) ? CMD_SHORT : CMD_FLUSH;
		end
	end

	// block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= end_of_block ? '0 : pos_next;
		end
	end

	// command queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_mem_q[wr_ptr_q] <= '{sample: sample_in, kind: kind_c, m: m_c, r: r_c};
		end
	end

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(accept) - QCNT_W'(cmd_pop);
		end
	end

endmodule

>>> src/gfre_back.sv
module gfre_back
	import gfre_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  cmd_t                          cmd,
	output logic                          cmd_pop,
	input  tap_arr_t                      taps,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          final_result,
	output logic                          too_short
);

	localparam logic signed [ACC_W-1:0] ACC_HALF    = ACC_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] ACC_HALF_M1 = ACC_W'(2 ** (FRAC_BITS - 1) - 1);
	localparam logic signed [ACC_W-1:0] ACC_SMAX    = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [ACC_W-1:0] ACC_SMIN    = -ACC_SMAX - ACC_W'(1);
	localparam int D_W = POS_W + 3;

	bk_state_t state_q, state_next;

	logic signed [SAMPLE_BITS-1:0] window_q [WIN];
	logic [POS_W-1:0]              m_q;
	logic [RAD_W-1:0]              r_q;
	logic                          last_q;
	logic [RAD_W-1:0]              e_q;
	logic [J_W-1:0]                j_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [PROD_W-1:0]      prod_s1;
	logic                          pv_s1;

	logic                          load;
	logic                          next_out;
	logic                          res_push;
	logic                          res_room;
	logic                          mac_done;
	res_t                          res_c;

	logic signed [D_W-1:0]         d0, d1, d2, m_s;
	logic [WIN_IDX_W-1:0]          win_idx;
	logic signed [D_W-1:0]         tt;
	logic [TAP_IDX_W-1:0]          tap_idx;
	logic signed [SAMPLE_BITS-1:0] win_sel;
	logic [TAP_W-1:0]              tap_sel;
	logic signed [PROD_W-1:0]      prod_c;
	logic signed [ACC_W-1:0]       rnd;
	logic signed [ACC_W-1:0]       q;
	logic signed [SAMPLE_BITS-1:0] sat_c;

	res_t              res_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              res_pop;

	// mirrored window address for the current tap
	always_comb begin
		m_s = D_W'(m_q);
		d0  = D_W'(e_q) + D_W'(r_q) - D_W'(j_q);
		if (d0 < 0) begin
			d1 = last_q ? (-d0 - D_W'(1)) : '0;
		end else begin
			d1 = d0;
		end
		d2 = (d1 > m_s) ? (m_s + m_s + D_W'(1) - d1) : d1;
		if (d2 < 0) begin
			win_idx = '0;
		end else if (d2 > D_W'(WIN - 1)) begin
			win_idx = WIN_IDX_W'(WIN - 1);
		end else begin
			win_idx = d2[WIN_IDX_W-1:0];
		end
		tt      = D_W'(j_q) - D_W'(r_q);
		tap_idx = (tt < 0) ? TAP_IDX_W'(-tt) : TAP_IDX_W'(tt);
		win_sel = window_q[win_idx];
		tap_sel = taps[tap_idx];
		prod_c  = $signed({1'b0, tap_sel}) * win_sel;
	end

	// round half away from zero, then saturate
	always_comb begin
		rnd = acc_q + (acc_q[ACC_W-1] ? ACC_HALF_M1 : ACC_HALF);
		q   = rnd >>> FRAC_BITS;
		if (q > ACC_SMAX) begin
			sat_c = ACC_SMAX[SAMPLE_BITS-1:0];
		end else if (q < ACC_SMIN) begin
			sat_c = ACC_SMIN[SAMPLE_BITS-1:0];
		end else begin
			sat_c = q[SAMPLE_BITS-1:0];
		end
	end

	assign mac_done = (j_q == {r_q, 1'b0});
	assign res_room = (cnt_q != QCNT_W'(QDEPTH));

	// sequencer next state and controls
	always_comb begin
		state_next = state_q;
		cmd_pop    = 1'b0;
		load       = 1'b0;
		next_out   = 1'b0;
		res_push   = 1'b0;
		res_c      = '{filtered: sat_c, final_result: (!last_q || e_q == '0) && last_q,
			too_short: 1'b0};
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					load    = 1'b1;
					case (cmd.kind)
						CMD_ONE, CMD_FLUSH: state_next = BK_MAC;
						CMD_SHORT:          state_next = BK_SHORT;
						default:            state_next = BK_IDLE;
					endcase
				end
			end
			BK_MAC: begin
				if (mac_done) begin
					state_next = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_next = BK_OUT;
			end
			BK_OUT: begin
				if (res_room) begin
					res_push = 1'b1;
					if (last_q && e_q != '0) begin
						next_out   = 1'b1;
						state_next = BK_MAC;
					end else begin
						state_next = BK_IDLE;
					end
				end
			end
			BK_SHORT: begin
				res_c = '{filtered: '0, final_result: 1'b1, too_short: 1'b1};
				if (res_room) begin
					res_push   = 1'b1;
					state_next = BK_IDLE;
				end
			end
			default: begin
				state_next = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// command context and tap counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= '0;
			r_q    <= '0;
			last_q <= 1'b0;
			e_q    <= '0;
			j_q    <= '0;
			pv_s1  <= 1'b0;
		end else begin
			pv_s1 <= (state_q == BK_MAC);
			if (load) begin
				m_q    <= cmd.m;
				r_q    <= cmd.r;
				last_q <= (cmd.kind == CMD_FLUSH);
				if (cmd.kind == CMD_FLUSH && cmd.m < POS_W'(cmd.r)) begin
					e_q <= cmd.m[RAD_W-1:0];
				end else begin
					e_q <= cmd.r;
				end
				j_q <= '0;
			end else if (next_out) begin
				e_q <= e_q - RAD_W'(1);
				j_q <= '0;
			end else if (state_q == BK_MAC) begin
				j_q <= j_q + J_W'(1);
			end
		end
	end

	// sample window, product register and accumulator
	always_ff @(posedge clk) begin
		if (load) begin
			window_q[0] <= cmd.sample;
			for (int i = 1; i < WIN; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
		prod_s1 <= prod_c;
		if (load || next_out) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	// result queue
	assign empty        = (cnt_q == '0);
	assign res_pop      = pop && !empty;
	assign filtered     = res_mem_q[rd_ptr_q].filtered;
	assign final_result = res_mem_q[rd_ptr_q].final_result;
	assign too_short    = res_mem_q[rd_ptr_q].too_short;

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[wr_ptr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(res_push) - QCNT_W'(res_pop);
		end
	end

endmodule

>>> src/gaussian_fir_reflect_edges.sv
// Symmetric Gaussian FIR (radius 0..6, Q1.15 taps) over blocks of signed 16-bit samples,
// with mirrored block edges. Each input sample, pushed through a queue-style port, yields
// at most one result once more than radius samples of the block have been seen; the
// sample flagged end_of_block flushes up to radius+1 results, or one too_short result
// when the block was shorter than radius. The user must write taps and radius through
// the cfg port only while the block is idle; the block itself does not enforce this.
// A front stage classifies samples into a two-entry command queue; the back end fetches
// each command and runs one tap per cycle through one shared multiplier. Results wait in
// a two-entry output queue, so both sides may stall independently.
module gaussian_fir_reflect_edges
	import gfre_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          end_of_block,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          final_result,
	output logic                          too_short,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [REG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	logic [RAD_W-1:0]     radius_q;
	tap_arr_t             taps_q;
	logic [REG_IDX_W-1:0] tap_wr_idx;
	logic                 cmd_valid;
	logic                 cmd_pop;
	cmd_t                 cmd;

	assign cfg_ready  = 1'b1;
	assign tap_wr_idx = cfg_index - REG_TAP_CENTER;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			taps_q   <= {{((TAP_COUNT - 1) * TAP_W){1'b0}}, TAP_ONE};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default:    taps_q[tap_wr_idx[TAP_IDX_W-1:0]] <= cfg_data[TAP_W-1:0];
			endcase
		end
	end

	gfre_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_in    (sample_in),
		.end_of_block (end_of_block),
		.radius       (radius_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	gfre_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.taps         (taps_q),
		.empty        (empty),
		.pop          (pop),
		.filtered     (filtered),
		.final_result (final_result),
		.too_short    (too_short)
	);

endmodule

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gfre_pkg::*;

	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEMS_PER_PHASE = 58;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          eob;
	} sample_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          end_of_block = 1'b0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic                          final_result;
	logic                          too_short;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [REG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]              cfg_data = '0;

	// stimulus and scoreboard state
	sample_item_t pending_samples[$];
	res_t         expected_outputs[$];
	logic         in_taken = 1'b0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	logic         hold_req = 1'b0;
	logic         hold_recv = 1'b0;
	int           mismatch_count = 0;
	int unsigned  cycle_count = 0;

	// shadow of the filter state
	logic signed [SAMPLE_BITS-1:0] shadow_window [WIN];
	int                            shadow_pos = 0;
	logic [RAD_W-1:0]              shadow_radius = '0;
	tap_arr_t                      shadow_taps;

	gaussian_fir_reflect_edges dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_in    (sample_in),
		.end_of_block (end_of_block),
		.empty        (empty),
		.pop          (pop),
		.filtered     (filtered),
		.final_result (final_result),
		.too_short    (too_short),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		shadow_taps = '0;
		shadow_taps[0] = TAP_ONE;
		for (int i = 0; i < WIN; i++) shadow_window[i] = '0;
	end

	// radius as the filter really uses it
	function automatic int active_radius();
		int r;
		r = int'(shadow_radius);
		if (r > MAX_RADIUS) r = MAX_RADIUS;
		if (r > TAP_COUNT - 1) r = TAP_COUNT - 1;
		return r;
	endfunction

	// window entry for kernel offset t of the output lag places behind the newest
	function automatic logic signed [SAMPLE_BITS-1:0] mirrored_sample(int m, int lag, int t,
			logic closing);
		int d;
		d = lag - t;
		if (d < 0) d = closing ? -d - 1 : 0;
		if (d > m) d = 2 * m + 1 - d;
		if (d < 0) d = 0;
		if (d > WIN - 1) d = WIN - 1;
		return shadow_window[d];
	endfunction

	// weighted sum, rounded half away from zero and saturated
	function automatic logic signed [SAMPLE_BITS-1:0] gaussian_point(int m, int lag, int r,
			logic closing);
		longint acc;
		longint q;
		longint hi;
		longint lo;
		int a;
		acc = 0;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		for (int t = -r; t <= r; t++) begin
			a = t < 0 ? -t : t;
			acc += longint'({1'b0, shadow_taps[a]}) * longint'(mirrored_sample(m, lag, t, closing));
		end
		if (acc >= 0) q = (acc + 16384) / 32768;
		else q = -((-acc + 16384) / 32768);
		if (q > hi) q = hi;
		if (q < lo) q = lo;
		return SAMPLE_BITS'(q);
	endfunction

	// advance the shadow state by one sample and queue what it yields
	function automatic void predict_smoothing(logic signed [SAMPLE_BITS-1:0] s, logic eob);
		int r;
		int m;
		int lag;
		res_t res;
		r = active_radius();
		for (int i = WIN - 1; i > 0; i--) shadow_window[i] = shadow_window[i-1];
		shadow_window[0] = s;
		if (shadow_pos < POS_SAT) shadow_pos++;
		m = shadow_pos - 1;
		if (!eob) begin
			if (m >= r) begin
				res.filtered = gaussian_point(m, r, r, 1'b0);
				res.final_result = 1'b0;
				res.too_short = 1'b0;
				expected_outputs.push_back(res);
			end
		end else begin
			shadow_pos = 0;
			if (m + 1 < r) begin
				res.filtered = '0;
				res.final_result = 1'b1;
				res.too_short = 1'b1;
				expected_outputs.push_back(res);
			end else begin
				lag = m < r ? m : r;
				for (; lag >= 0; lag--) begin
					res.filtered = gaussian_point(m, lag, r, 1'b1);
					res.final_result = (lag == 0);
					res.too_short = 1'b0;
					expected_outputs.push_back(res);
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// sample driver, fed from the pending queue
	always @(negedge clk) begin
		sample_item_t nxt;
		if (!push || in_taken) begin
			if (arst_n && pending_samples.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				nxt = pending_samples.pop_front();
				push <= 1'b1;
				sample_in <= nxt.sample;
				end_of_block <= nxt.eob;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side back pressure
	always @(negedge clk) begin
		pop <= arst_n && !hold_recv && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin
		wait (hold_req);
		hold_recv = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_recv = 1'b0;
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		res_t want;
		in_taken <= push && !full;
		if (push && !full) predict_smoothing(sample_in, end_of_block);
		if (pop && !empty) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch($sformatf("unexpected result filtered=%0d final=%0b short=%0b",
					filtered, final_result, too_short));
			end else begin
				want = expected_outputs.pop_front();
				if (filtered !== want.filtered)
					report_mismatch($sformatf("filtered %0d, want %0d", filtered, want.filtered));
				if (final_result !== want.final_result)
					report_mismatch($sformatf("final_result %0b, want %0b", final_result,
						want.final_result));
				if (too_short !== want.too_short)
					report_mismatch($sformatf("too_short %0b, want %0b", too_short,
						want.too_short));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one register write transaction, mirrored into the shadow state
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_RADIUS) shadow_radius = val[RAD_W-1:0];
		else shadow_taps[idx - REG_TAP_CENTER] = val[TAP_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_kernel(input int unsigned rad, input tap_arr_t k);
		write_reg(REG_RADIUS, CFG_W'(rad));
		for (int d = 0; d < TAP_COUNT; d++)
			write_reg(REG_TAP_CENTER + REG_IDX_W'(d), k[d]);
	endtask

	// wait for all samples taken and all results checked, then let the block settle
	task automatic wait_drained();
		@(posedge clk);
		while (pending_samples.size() != 0 || push) @(posedge clk);
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_sample(input int v, input logic eob);
		sample_item_t it;
		it.sample = SAMPLE_BITS'(v);
		it.eob = eob;
		pending_samples.push_back(it);
	endtask

	task automatic queue_block(input int len);
		int v;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(7))
				0: v = 32767;
				1: v = -32768;
				2: v = $urandom_range(0, 15) - 8;
				default: v = int'($urandom);
			endcase
			queue_sample(v, i == len - 1);
		end
	endtask

	// roughly bell-shaped taps, sometimes with one weight above one
	task automatic random_kernel(output tap_arr_t k);
		k[0] = TAP_W'($urandom_range(4000, 32768));
		for (int d = 1; d < TAP_COUNT; d++) k[d] = TAP_W'($urandom_range(0, k[d-1]));
		if ($urandom_range(3) == 0)
			k[$urandom_range(0, TAP_COUNT - 1)] = TAP_W'($urandom_range(32769, 65535));
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int unsigned rad);
		tap_arr_t k;
		int added;
		int len;
		int r;
		random_kernel(k);
		load_kernel(rad, k);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		r = active_radius();
		added = 0;
		while (added < ITEMS_PER_PHASE) begin
			if (r > 0 && $urandom_range(5) == 0) len = $urandom_range(1, r);
			else if ($urandom_range(9) == 0) len = $urandom_range(r + 1, 30);
			else len = $urandom_range(r > 0 ? r : 1, r + 10);
			queue_block(len);
			added += len;
		end
		wait_drained();
	endtask

	initial begin
		tap_arr_t k;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset kernel passes samples through
		queue_sample(32767, 1'b0);
		queue_sample(-32768, 1'b0);
		queue_sample(1, 1'b1);
		wait_drained();

		// radius beyond limit, full-scale samples, then a short block
		k[0] = 16'd8192; k[1] = 16'd7000; k[2] = 16'd5000; k[3] = 16'd3000;
		k[4] = 16'd1500; k[5] = 16'd0; k[6] = 16'd32768;
		load_kernel(7, k);
		queue_sample(32767, 1'b0);
		queue_sample(-32768, 1'b0);
		queue_sample(32767, 1'b0);
		queue_sample(12345, 1'b0);
		queue_sample(-1, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(-32768, 1'b0);
		queue_sample(32767, 1'b1);
		queue_sample(5, 1'b0);
		queue_sample(-5, 1'b0);
		queue_sample(7, 1'b1);
		wait_drained();

		// taps above one drive the sum into saturation, single-sample short block
		k[0] = 16'd65535; k[1] = 16'd32768; k[2] = 16'd16384; k[3] = 16'd0;
		k[4] = 16'd0; k[5] = 16'd0; k[6] = 16'd0;
		load_kernel(2, k);
		queue_sample(32767, 1'b0);
		queue_sample(32767, 1'b0);
		queue_sample(-32768, 1'b0);
		queue_sample(100, 1'b1);
		queue_sample(-32768, 1'b1);
		wait_drained();

		// half-weight rounding, radius shrinks in the middle of a block
		k[0] = 16'd16384; k[1] = 16'd0; k[2] = 16'd8192; k[3] = 16'd1;
		load_kernel(3, k);
		queue_sample(1, 1'b0);
		queue_sample(-1, 1'b0);
		queue_sample(3, 1'b0);
		queue_sample(-3, 1'b0);
		wait_drained();
		write_reg(REG_RADIUS, CFG_W'(1));
		queue_sample(-32768, 1'b0);
		queue_sample(32767, 1'b1);
		wait_drained();

		// random blocks under several idling mixes
		hold_req = 1'b1;
		run_phase(0, 0, 6);
		run_phase(75, 0, $urandom_range(1, 5));
		run_phase(0, 75, 7);
		run_phase(28, 28, $urandom_range(0, 7));

		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> gaussian_fir_reflect_edges.f
src/gfre_pkg.sv
src/gfre_front.sv
src/gfre_back.sv
src/gaussian_fir_reflect_edges.sv
bench/testbench.sv
